// File: sv/idf_pkg.sv
// ----------------------------------------------------------------------------
// idf_pkg
// Types, character codes and state encodings shared by the ISO 8601 duration
// formatter and its submodules.
// ----------------------------------------------------------------------------
package idf_pkg;

    localparam int DAY_BITS    = 31;
    localparam int SECS_BITS   = 17;
    localparam int SECS_DIGITS = 5;
    localparam int SECS_NDW    = 3;
    localparam int USEC_BITS   = 20;
    localparam int USEC_DIGITS = 6;
    localparam int USEC_NDW    = 3;

    localparam logic [SECS_BITS-1:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [SECS_BITS-1:0] SECS_LAST      = 17'd86399;
    localparam logic [USEC_BITS-1:0] MICROS_PER_SEC = 20'd1000000;
    localparam logic [USEC_BITS-1:0] MICROS_MAX     = 20'd999999;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_P     = 7'h50;
    localparam logic [6:0] CH_D     = 7'h44;
    localparam logic [6:0] CH_T     = 7'h54;
    localparam logic [6:0] CH_S     = 7'h53;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    typedef struct packed {
        logic signed [30:0] span_days;
        logic [16:0]        span_seconds;
        logic [19:0]        span_micros;
    } span_t;

    typedef struct packed {
        logic [6:0] text_char;
        logic       is_last;
    } text_t;

    // Conversion results handed from the front end to the character sequencer.
    typedef struct packed {
        logic                       neg;
        logic [SECS_DIGITS*4-1:0]   secs_digits;
        logic [SECS_NDW-1:0]        secs_ndig;
        logic [USEC_DIGITS*4-1:0]   usec_digits;
        logic                       usec_nz;
    } emit_info_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_NORM,
        FS_SIGN,
        FS_FIX,
        FS_START,
        FS_CONV,
        FS_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        EM_IDLE,
        EM_MINUS,
        EM_P,
        EM_DAYS,
        EM_DAY_D,
        EM_ZERO,
        EM_ZERO_D,
        EM_T,
        EM_SECS,
        EM_DOT,
        EM_USEC,
        EM_S
    } emit_state_t;

    // Largest day count that fits in the given number of decimal digits.
    function automatic logic [63:0] day_cap(input int digits);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < digits; i++)
        begin
            v = v * 64'd10;
        end
        return v - 64'd1;
    endfunction

endpackage

// File: sv/idf_bcd_conv.sv
// ----------------------------------------------------------------------------
// idf_bcd_conv
// Bit-serial binary to BCD converter (shift and add three), one input bit per
// clock, with a count of significant decimal digits.
// ----------------------------------------------------------------------------
module idf_bcd_conv #(
    parameter int WIDTH  = 31,
    parameter int DIGITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [WIDTH-1:0]             value,
    output logic                         done,
    output logic [DIGITS*4-1:0]          digits,
    output logic [$clog2(DIGITS+1)-1:0]  ndig
);

    localparam int CW = $clog2(WIDTH + 1);
    localparam int NW = $clog2(DIGITS + 1);
    localparam int BW = DIGITS * 4;

    logic [WIDTH-1:0] shift_reg, shift_next;
    logic [BW-1:0]    bcd_reg, bcd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [BW-1:0]    bcd_adj;
    logic [NW-1:0]    ndig_c;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                bcd_reg[i*4 +: 4] + 4'd3 : bcd_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            shift_next = value;
            bcd_next   = '0;
            cnt_next   = CW'(WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            bcd_next   = {bcd_adj[BW-2:0], shift_reg[WIDTH-1]};
            shift_next = shift_reg << 1;
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    // The highest nonzero digit sets the count; zero gives a count of zero.
    always_comb
    begin
        ndig_c = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                ndig_c = NW'(i + 1);
            end
        end
    end

    assign done   = (cnt_reg == '0);
    assign digits = bcd_reg;
    assign ndig   = ndig_c;

endmodule

// File: sv/idf_emit.sv
// ----------------------------------------------------------------------------
// idf_emit
// Character sequencer: walks the duration text one character per clock, when
// not stalled, into an output register, without day and second leading zeros.
// ----------------------------------------------------------------------------
module idf_emit import idf_pkg::*; #(
    parameter int DAY_DIGITS = 9
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  emit_info_t                       info,
    input  logic [DAY_DIGITS*4-1:0]          day_digits,
    input  logic [$clog2(DAY_DIGITS+1)-1:0]  day_ndig,
    output logic                             text_valid,
    input  logic                             text_stall,
    output text_t                            text,
    output logic                             done
);

    localparam int IW = $clog2((DAY_DIGITS > USEC_DIGITS) ? DAY_DIGITS : USEC_DIGITS);

    emit_state_t     state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            text_valid_reg, text_valid_next;
    text_t           text_data_reg, text_data_next;

    logic            can_load;
    logic            load;
    logic            time_nz;
    logic [3:0]      day_sel, secs_sel, usec_sel;

    assign can_load = !text_valid_reg || !text_stall;
    assign time_nz  = (info.secs_ndig != '0) || info.usec_nz;

    always_comb
    begin
        day_sel  = 4'd0;
        secs_sel = 4'd0;
        usec_sel = 4'd0;
        for (int i = 0; i < DAY_DIGITS; i++)
        begin
            if (idx_reg == IW'(i))
            begin
                day_sel = day_digits[i*4 +: 4];
            end
        end
        for (int i = 0; i < SECS_DIGITS; i++)
        begin
            if (idx_reg == IW'(i))
            begin
                secs_sel = info.secs_digits[i*4 +: 4];
            end
        end
        for (int i = 0; i < USEC_DIGITS; i++)
        begin
            if (idx_reg == IW'(i))
            begin
                usec_sel = info.usec_digits[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        text_data_next = text_data_reg;
        load           = 1'b0;
        done           = 1'b0;

        case (state_reg)
            EM_IDLE:
            begin
                if (go)
                begin
                    state_next = info.neg ? EM_MINUS : EM_P;
                end
            end
            EM_MINUS:
            begin
                text_data_next = '{text_char: CH_MINUS, is_last: 1'b0};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = EM_P;
                end
            end
            EM_P:
            begin
                text_data_next = '{text_char: CH_P, is_last: 1'b0};
                if (can_load)
                begin
                    load = 1'b1;
                    if (day_ndig != '0)
                    begin
                        state_next = EM_DAYS;
                        idx_next   = IW'(day_ndig - 1'b1);
                    end
                    else if (time_nz)
                    begin
                        state_next = EM_T;
                    end
                    else
                    begin
                        state_next = EM_ZERO;
                    end
                end
            end
            EM_DAYS:
            begin
                text_data_next = '{text_char: CH_ZERO + {3'b000, day_sel}, is_last: 1'b0};
                if (can_load)
                begin
                    load = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = EM_DAY_D;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            EM_DAY_D:
            begin
                text_data_next = '{text_char: CH_D, is_last: !time_nz};
                if (can_load)
                begin
                    load = 1'b1;
                    if (time_nz)
                    begin
                        state_next = EM_T;
                    end
                    else
                    begin
                        state_next = EM_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            EM_ZERO:
            begin
                text_data_next = '{text_char: CH_ZERO, is_last: 1'b0};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = EM_ZERO_D;
                end
            end
            EM_ZERO_D:
            begin
                text_data_next = '{text_char: CH_D, is_last: 1'b1};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = EM_IDLE;
                    done       = 1'b1;
                end
            end
            EM_T:
            begin
                text_data_next = '{text_char: CH_T, is_last: 1'b0};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = EM_SECS;
                    // A zero second count still prints a single zero.
                    idx_next   = (info.secs_ndig == '0) ? '0 :
                                 IW'(info.secs_ndig - 1'b1);
                end
            end
            EM_SECS:
            begin
                text_data_next = '{text_char: CH_ZERO + {3'b000, secs_sel}, is_last: 1'b0};
                if (can_load)
                begin
                    load = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = info.usec_nz ? EM_DOT : EM_S;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            EM_DOT:
            begin
                text_data_next = '{text_char: CH_DOT, is_last: 1'b0};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = EM_USEC;
                    idx_next   = IW'(USEC_DIGITS - 1);
                end
            end
            EM_USEC:
            begin
                text_data_next = '{text_char: CH_ZERO + {3'b000, usec_sel}, is_last: 1'b0};
                if (can_load)
                begin
                    load = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = EM_S;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            EM_S:
            begin
                text_data_next = '{text_char: CH_S, is_last: 1'b1};
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = EM_IDLE;
                    done       = 1'b1;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase

        if (load)
        begin
            text_valid_next = 1'b1;
        end
        else if (!text_stall)
        begin
            text_valid_next = 1'b0;
        end
        else
        begin
            text_valid_next = text_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= EM_IDLE;
            idx_reg        <= '0;
            text_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            text_valid_reg <= text_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            text_data_reg <= text_data_next;
        end
    end

    assign text_valid = text_valid_reg;
    assign text       = text_data_reg;

endmodule

// File: sv/iso_duration_formatter_unit.sv
// ----------------------------------------------------------------------------
// iso_duration_formatter_unit
// Formats a span of signed days, seconds and microseconds as ISO 8601
// duration text, one ASCII character per output request.
// ----------------------------------------------------------------------------
// Flow: a taken span is normalised, its sign and fraction are fixed, then the
// BCD conversions run and one character per cycle follows while the output is
// not stalled. A new span is taken only once the last of its 3..26 characters
// is loaded; the 31-bit serial BCD conversion of the day magnitude is longest.
// Reset clears the control state and the output valid; no request is pending.
// ----------------------------------------------------------------------------
module iso_duration_formatter_unit import idf_pkg::*; #(
    parameter int MAX_DAY_DIGITS = 9
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  span_valid,
    output logic  span_stall,
    input  span_t span,
    output logic  text_valid,
    input  logic  text_stall,
    output text_t text
);

    localparam logic [63:0] DAY_CAP = day_cap(MAX_DAY_DIGITS);
    localparam int          DNW     = $clog2(MAX_DAY_DIGITS + 1);

    ctrl_state_t            state_reg, state_next;
    logic signed [31:0]     days_reg, days_next;
    logic [SECS_BITS-1:0]   secs_reg, secs_next;
    logic [USEC_BITS-1:0]   usec_reg, usec_next;
    logic [DAY_BITS-1:0]    dmag_reg, dmag_next;
    logic                   neg_reg, neg_next;

    logic signed [31:0]     neg_days;
    logic [DAY_BITS-1:0]    dsat;
    logic                   conv_start;
    logic                   emit_go;
    logic                   emit_done;

    logic                            day_done, secs_done, usec_done;
    logic [MAX_DAY_DIGITS*4-1:0]     day_digits;
    logic [DNW-1:0]                  day_ndig;
    logic [SECS_DIGITS*4-1:0]        secs_digits;
    logic [SECS_NDW-1:0]             secs_ndig;
    logic [USEC_DIGITS*4-1:0]        usec_digits;
    logic [USEC_NDW-1:0]             usec_ndig;
    emit_info_t                      info;

    assign span_stall = (state_reg != FS_IDLE);
    assign neg_days   = -days_reg;
    assign dsat       = ({33'd0, dmag_reg} > DAY_CAP) ? DAY_CAP[DAY_BITS-1:0] : dmag_reg;

    always_comb
    begin
        state_next = state_reg;
        days_next  = days_reg;
        secs_next  = secs_reg;
        usec_next  = usec_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        conv_start = 1'b0;
        emit_go    = 1'b0;

        case (state_reg)
            FS_IDLE:
            begin
                if (span_valid)
                begin
                    days_next  = {span.span_days[30], span.span_days};
                    secs_next  = span.span_seconds;
                    usec_next  = span.span_micros;
                    state_next = FS_NORM;
                end
            end
            FS_NORM:
            begin
                // Seconds past one day carry into the day count.
                if (secs_reg >= SECS_PER_DAY)
                begin
                    days_next = days_reg + 32'sd1;
                    secs_next = secs_reg - SECS_PER_DAY;
                end
                if (usec_reg > MICROS_MAX)
                begin
                    usec_next = MICROS_MAX;
                end
                state_next = FS_SIGN;
            end
            FS_SIGN:
            begin
                neg_next = days_reg[31];
                if (days_reg[31])
                begin
                    if (secs_reg == '0)
                    begin
                        dmag_next = neg_days[DAY_BITS-1:0];
                    end
                    else
                    begin
                        dmag_next = ~days_reg[DAY_BITS-1:0];
                        secs_next = SECS_PER_DAY - secs_reg;
                    end
                end
                else
                begin
                    dmag_next = days_reg[DAY_BITS-1:0];
                end
                state_next = FS_FIX;
            end
            FS_FIX:
            begin
                // A negative span shows its fraction as a complement, so one
                // second is borrowed, from the days when the seconds are zero.
                if (neg_reg && (usec_reg != '0))
                begin
                    usec_next = MICROS_PER_SEC - usec_reg;
                    if (secs_reg == '0)
                    begin
                        secs_next = SECS_LAST;
                        dmag_next = dmag_reg - 1'b1;
                    end
                    else
                    begin
                        secs_next = secs_reg - 1'b1;
                    end
                end
                state_next = FS_START;
            end
            FS_START:
            begin
                conv_start = 1'b1;
                state_next = FS_CONV;
            end
            FS_CONV:
            begin
                if (day_done && secs_done && usec_done)
                begin
                    emit_go    = 1'b1;
                    state_next = FS_EMIT;
                end
            end
            FS_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg <= days_next;
        secs_reg <= secs_next;
        usec_reg <= usec_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    idf_bcd_conv #(
        .WIDTH  (DAY_BITS),
        .DIGITS (MAX_DAY_DIGITS)
    ) u_day_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .value  (dsat),
        .done   (day_done),
        .digits (day_digits),
        .ndig   (day_ndig)
    );

    idf_bcd_conv #(
        .WIDTH  (SECS_BITS),
        .DIGITS (SECS_DIGITS)
    ) u_secs_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .value  (secs_reg),
        .done   (secs_done),
        .digits (secs_digits),
        .ndig   (secs_ndig)
    );

    idf_bcd_conv #(
        .WIDTH  (USEC_BITS),
        .DIGITS (USEC_DIGITS)
    ) u_usec_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .value  (usec_reg),
        .done   (usec_done),
        .digits (usec_digits),
        .ndig   (usec_ndig)
    );

    assign info = '{
        neg:         neg_reg,
        secs_digits: secs_digits,
        secs_ndig:   secs_ndig,
        usec_digits: usec_digits,
        usec_nz:     (usec_ndig != '0)
    };

    idf_emit #(
        .DAY_DIGITS (MAX_DAY_DIGITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (emit_go),
        .info       (info),
        .day_digits (day_digits),
        .day_ndig   (day_ndig),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .done       (emit_done)
    );

endmodule

// File: bench/iso_duration_formatter_unit_tb.sv
// ----------------------------------------------------------------------------
// iso_duration_formatter_unit_tb
// Drives signed day/second/microsecond spans into the duration formatter and
// checks every emitted character against a predicted ISO 8601 duration text.
// Both handshakes see random stalls and gaps, with quiet stretches in between.
// ----------------------------------------------------------------------------
module iso_duration_formatter_unit_tb import idf_pkg::*; ();

    localparam longint unsigned DAY_LIMIT = 64'd999_999_999;
    localparam int RANDOM_SPANS = 210;
    localparam int SETTLE_CYCLES = 60;

    // Holds the characters still owed by the block and checks each one as it
    // arrives.
    class iso_text_scoreboard;
        text_t due_chars[$];
        int errors;
        int spans;
        int chars;
        int negatives;
        int capped;
        int fractional;

        function int pending();
            return due_chars.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
            begin
                $display("ERROR: %s", msg);
            end
        endfunction

        function void put_char(logic [6:0] c);
            text_t t;
            t.text_char = c;
            t.is_last = 1'b0;
            due_chars.push_back(t);
        endfunction

        function void put_decimal(longint unsigned v);
            logic [6:0] digs[$];
            do
            begin
                digs.push_front(7'(CH_ZERO + v % 10));
                v = v / 10;
            end
            while (v != 0);
            foreach (digs[k])
            begin
                put_char(digs[k]);
            end
        endfunction

        // Works out the duration text for one accepted request.
        function void note_span(span_t s);
            longint signed days_in;
            longint signed total;
            longint unsigned mag;
            longint unsigned days;
            longint unsigned secs;
            longint unsigned usec;
            longint unsigned div;
            bit neg;
            text_t t;
            days_in = longint'({{33{s.span_days[30]}}, s.span_days});
            usec = (s.span_micros > MICROS_MAX) ? longint'(MICROS_MAX)
                                                : longint'(s.span_micros);
            total = days_in * longint'(SECS_PER_DAY) + longint'(s.span_seconds);
            neg = total < 0;
            mag = neg ? -total : total;
            days = mag / longint'(SECS_PER_DAY);
            secs = mag % longint'(SECS_PER_DAY);
            // The complemented microseconds borrow one second, which may come
            // out of the day count.
            if (neg && usec != 0)
            begin
                usec = longint'(MICROS_PER_SEC) - usec;
                if (secs == 0)
                begin
                    secs = longint'(SECS_LAST);
                    days--;
                end
                else
                begin
                    secs--;
                end
            end
            if (days > DAY_LIMIT)
            begin
                days = DAY_LIMIT;
                capped++;
            end

            if (neg)
            begin
                put_char(CH_MINUS);
                negatives++;
            end
            put_char(CH_P);
            if (days != 0)
            begin
                put_decimal(days);
                put_char(CH_D);
            end
            if (secs == 0 && usec == 0)
            begin
                if (days == 0)
                begin
                    put_char(CH_ZERO);
                    put_char(CH_D);
                end
            end
            else
            begin
                put_char(CH_T);
                put_decimal(secs);
                if (usec != 0)
                begin
                    fractional++;
                    put_char(CH_DOT);
                    for (div = 100000; div > 0; div = div / 10)
                    begin
                        put_char(7'(CH_ZERO + (usec / div) % 10));
                    end
                end
                put_char(CH_S);
            end
            t = due_chars.pop_back();
            t.is_last = 1'b1;
            due_chars.push_back(t);
            spans++;
        endfunction

        function void check_text(text_t got);
            text_t want;
            chars++;
            if (due_chars.size() == 0)
            begin
                note_error($sformatf("unexpected character 0x%02h is_last=%0b",
                                     got.text_char, got.is_last));
                return;
            end
            want = due_chars.pop_front();
            if (got.text_char !== want.text_char)
            begin
                note_error($sformatf("character %0d: expected '%c' (0x%02h), got 0x%02h",
                                     chars, want.text_char, want.text_char,
                                     got.text_char));
            end
            if (got.is_last !== want.is_last)
            begin
                note_error($sformatf("character %0d: expected is_last=%0b, got %0b",
                                     chars, want.is_last, got.is_last));
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  span_valid = 1'b0;
    logic  span_stall;
    span_t span = '0;
    logic  text_valid;
    logic  text_stall = 1'b0;
    text_t text;

    bit no_gaps = 1'b0;
    iso_text_scoreboard board = new();

    iso_duration_formatter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .span       (span),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function span_t mk_span(longint d, longint sec, longint us);
        span_t s;
        s.span_days = d[30:0];
        s.span_seconds = sec[16:0];
        s.span_micros = us[19:0];
        return s;
    endfunction

    function span_t random_span();
        span_t s;
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 30)
            d = int'($urandom_range(0, 6)) - 3;
        else if (r < 60)
            d = int'($urandom_range(0, 199998)) - 99999;
        else if (r < 85)
            d = int'($urandom);
        else if (r < 93)
            d = ($urandom_range(0, 1) ? -1 : 1) * (999999990 + int'($urandom_range(0, 20)));
        else
            d = $urandom_range(0, 1) ? 32'h3FFFFFFF : 32'hC0000000;
        s.span_days = d[30:0];

        r = $urandom_range(0, 99);
        if (r < 70)
            s.span_seconds = 17'($urandom_range(0, 86399));
        else if (r < 80)
            s.span_seconds = '0;
        else if (r < 90)
            s.span_seconds = 17'($urandom_range(86400, 131071));
        else
            s.span_seconds = 17'($urandom);

        r = $urandom_range(0, 99);
        if (r < 30)
            s.span_micros = '0;
        else if (r < 80)
            s.span_micros = 20'($urandom_range(0, 999999));
        else if (r < 88)
            s.span_micros = 20'($urandom_range(1, 9));
        else if (r < 94)
            s.span_micros = 20'($urandom_range(1000000, 1048575));
        else
            s.span_micros = 20'($urandom);
        return s;
    endfunction

    // Presents one request, holds it until taken, then idles for a random gap, if any.
    task automatic push_span(span_t s);
        int gap;
        @(negedge clk);
        span <= s;
        span_valid <= 1'b1;
        @(posedge clk);
        while (span_stall)
        begin
            @(posedge clk);
        end
        board.note_span(s);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            span_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        span_valid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Output stall pattern: runs of ready cycles broken by random stalls.
    initial
    begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0 && !no_gaps)
            begin
                text_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                text_stall <= 1'b0;
                if (run_left > 0)
                begin
                    run_left--;
                end
                else
                begin
                    stall_left = pick_gap();
                    run_left = $urandom_range(0, 6);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && text_valid && !text_stall)
        begin
            board.check_text(text);
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_span(mk_span(0, 0, 0));
        push_span(mk_span(0, 0, 1));
        push_span(mk_span(0, 1, 0));
        push_span(mk_span(1, 0, 0));
        push_span(mk_span(-1, 0, 0));
        // Negative with microseconds and no seconds left: borrow from days.
        push_span(mk_span(-1, 0, 5));
        push_span(mk_span(-1, 86399, 999999));
        push_span(mk_span(0, 86399, 999999));
        // Seconds past the end of the day roll into the day count.
        push_span(mk_span(0, 86400, 0));
        push_span(mk_span(0, 131071, 0));
        push_span(mk_span(-1, 86400, 0));
        push_span(mk_span(-2, 131071, 500000));
        // Microseconds above range saturate.
        push_span(mk_span(5, 12345, 1048575));
        // Day magnitudes beyond nine digits saturate.
        push_span(mk_span(1073741823, 131071, 1048575));
        push_span(mk_span(-1073741824, 0, 0));
        push_span(mk_span(-1073741824, 0, 1));
        push_span(mk_span(1000000000, 0, 0));
        push_span(mk_span(999999999, 86399, 999999));
        push_span(mk_span(-999999999, 0, 1));
        push_span(mk_span(-5, 86399, 0));
        push_span(mk_span(0, 0, 999999));
        push_span(mk_span(3, 0, 100));
        wait_for_drain();

        for (int i = 0; i < RANDOM_SPANS; i++)
        begin
            no_gaps = (i >= 100 && i < 140);
            if (i == 80 || i == 160)
            begin
                wait_for_drain();
            end
            push_span(random_span());
        end
        no_gaps = 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Formatted %0d spans into %0d characters: %0d negative, %0d fractional,",
                 board.spans, board.chars, board.negatives, board.fractional);
        $display("%0d day counts saturated, %0d errors.", board.capped, board.errors);
        if (board.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Run timed out with %0d characters outstanding.", board.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
